[design/centroid_bounding_sphere_assert.svh]
// Assertion macros for the centroid bounding sphere block.
// Included by the top level, which checks its own sequencing; no other dependencies.
`ifndef CENTROID_BOUNDING_SPHERE_ASSERT_SVH
`define CENTROID_BOUNDING_SPHERE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold too.
`define CBS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("centroid bounding sphere: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next cycle.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("centroid bounding sphere: next-cycle check failed");

`else

`define CBS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/cbs_pkg.sv]
// Shared types and constants for the centroid bounding sphere block.
// No dependencies; the top level and the testbench import it, and the interfaces use its types.
package cbs_pkg;

   // Field widths fixed by the Q16.8 coordinate format.
   localparam int COORD_W  = 24;
   localparam int RADIUS_W = 26;
   localparam int AXES     = 3;
   localparam int PROD_W   = 2 * COORD_W;
   // Sum of three squared differences, each below 2**48.
   localparam int DIST_W   = 50;

   // Phases of the per-vertex multiply pass.
   localparam logic [2:0] PHASE_FIRST     = 3'd0;
   localparam logic [2:0] PHASE_ACC_START = 3'd2;
   localparam logic [2:0] PHASE_LAST      = 3'd4;

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      no_vertex;
      logic                      last;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RADIUS_W-1:0]       sphere_radius;
      logic                      empty_set;
      logic                      overflowed;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_DIV_START,
      S_DIV_WAIT,
      S_WALK_RD,
      S_WALK_MUL,
      S_WALK_CMP,
      S_SQRT,
      S_FIN
   } state_type;

endpackage

[design/cbs_stream_if.sv]
// Valid/ready channel interfaces for the vertex input and the sphere result.
// Depends on cbs_pkg for the payload types.
interface cbs_req_if;
   logic                     valid;
   logic                     ready;
   cbs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cbs_rsp_if;
   logic                     valid;
   logic                     ready;
   cbs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/cbs_divider.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its parameters; used by the top level for each axis.
module cbs_divider #(
   parameter int DIVIDEND_W = 35,
   parameter int DIVISOR_W  = 11,
   parameter int QUOT_W     = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic        [DIVISOR_W-1:0]  divisor,
   output logic                         done,
   output logic signed [QUOT_W-1:0]     quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] mag_ff, mag_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVIDEND_W-1:0] quo_signed;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      step_in    = step_ff;
      mag_in     = mag_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, mag_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in    = 1'b1;
         neg_in     = dividend[DIVIDEND_W-1];
         mag_in     = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
         quo_in     = '0;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = STEP_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         mag_in  = {mag_ff[DIVIDEND_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, divisor_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff     <= neg_in;
      step_ff    <= step_in;
      mag_ff     <= mag_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   // Restore the sign; the magnitude of the quotient fits the result width.
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[QUOT_W-1:0];
   assign done       = done_ff;

endmodule

[design/centroid_bounding_sphere.sv]
// Centroid bounding sphere: top level with the sequencer, vertex store and shared units.
// Depends on cbs_pkg, cbs_stream_if, cbs_divider and centroid_bounding_sphere_assert.svh.
//
// Vertices arrive one word per cycle on req while the block loads, and are stored while
// running coordinate sums are kept; a word with last set closes the set, and one result
// word leaves on rsp. After a closing word of a set that holds vertices, the block stops
// taking input while the serial divider forms the three centroid coordinates one bit per
// cycle, the walk visits each vertex on its single read port and shared multiplier, and
// the square root takes one step per result bit. If the previous result still waits on
// rsp, the block holds the new one until it is taken. An empty set reports empty_set
// with a zero center and radius, and vertices beyond MAX_VERTICES are dropped and
// reported through overflowed.
`include "centroid_bounding_sphere_assert.svh"

module centroid_bounding_sphere #(
   parameter int MAX_VERTICES = 1024
) (
   input logic       clock,
   input logic       reset,
   cbs_req_if.sink   req,
   cbs_rsp_if.source rsp
);

   import cbs_pkg::*;

   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W  = $clog2(MAX_VERTICES);
   localparam int SUM_W   = COORD_W + CNT_W;
   localparam int STORE_W = AXES * COORD_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]                count_ff, count_in;
   logic [AXES-1:0][SUM_W-1:0]      sum_ff, sum_in;
   logic                            dropped_ff, dropped_in;
   logic                            empty_ff, empty_in;
   logic [1:0]                      axis_ff, axis_in;
   logic [AXES-1:0][COORD_W-1:0]    center_ff, center_in;
   logic [CNT_W-1:0]                walk_idx_ff, walk_idx_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [COORD_W-1:0]              diff_ff, diff_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic [DIST_W-1:0]               acc_ff, acc_in;
   logic [DIST_W-1:0]               best_ff, best_in;
   logic [DIST_W-1:0]               rem_ff, rem_in;
   logic [DIST_W-1:0]               root_ff, root_in;
   logic [DIST_W-1:0]               bit_ff, bit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                 rsp_data_ff, rsp_data_in;

   logic [STORE_W-1:0]              store_mem [MAX_VERTICES];
   logic [AXES-1:0][COORD_W-1:0]    rd_data_ff;
   logic [AXES-1:0][COORD_W-1:0]    wr_word;

   logic                            accept;
   logic                            add_vertex;
   logic                            drop_vertex;
   logic                            closing;
   logic                            closing_empty;
   logic                            div_start;
   logic                            div_done;
   logic signed [COORD_W-1:0]       div_quot;
   logic                            fin_load;
   logic                            walk_last;
   logic                            sqrt_done;
   logic [1:0]                      diff_axis;
   logic [COORD_W:0]                diff_wide;
   logic [DIST_W-1:0]               root_plus_bit;
   logic [DIST_W-1:0]               best_next;

   // Handshake and sequencer decodes.
   always_comb begin
      req.ready     = (state_ff == S_LOAD);
      accept        = req.valid && req.ready;
      add_vertex    = accept && !req.payload.no_vertex && (count_ff != CNT_W'(MAX_VERTICES));
      drop_vertex   = accept && !req.payload.no_vertex && (count_ff == CNT_W'(MAX_VERTICES));
      closing       = accept && req.payload.last;
      closing_empty = (count_ff == '0) && !add_vertex;
      div_start     = (state_ff == S_DIV_START);
      fin_load      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp.ready);
      walk_last     = (walk_idx_ff + 1'b1) == count_ff;
      sqrt_done     = (bit_ff == '0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (closing) begin
               state_in = closing_empty ? S_FIN : S_DIV_START;
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = (axis_ff == AXIS_LAST) ? S_WALK_RD : S_DIV_START;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_MUL;
         end
         S_WALK_MUL: begin
            if (phase_ff == PHASE_LAST) begin
               state_in = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            state_in = walk_last ? S_SQRT : S_WALK_RD;
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_load) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Absolute coordinate difference for the axis of the current multiply phase.
   always_comb begin
      diff_axis = (phase_ff < 3'(AXES)) ? phase_ff[1:0] : AXIS_X;
      diff_wide = {rd_data_ff[diff_axis][COORD_W-1], rd_data_ff[diff_axis]}
                - {center_ff[diff_axis][COORD_W-1], center_ff[diff_axis]};
      diff_in   = diff_wide[COORD_W] ? COORD_W'(~diff_wide + 1'b1) : diff_wide[COORD_W-1:0];
      prod_in   = diff_ff * diff_ff;
   end

   // Datapath register updates by state.
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      dropped_in    = dropped_ff;
      empty_in      = empty_ff;
      axis_in       = axis_ff;
      center_in     = center_ff;
      walk_idx_in   = walk_idx_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      root_plus_bit = root_ff + bit_ff;
      best_next     = (acc_ff > best_ff) ? acc_ff : best_ff;

      // Loading: store, sum and count each vertex that fits.
      if (add_vertex) begin
         count_in  = count_ff + 1'b1;
         sum_in[0] = sum_ff[0] + {{CNT_W{req.payload.coord_x[COORD_W-1]}}, req.payload.coord_x};
         sum_in[1] = sum_ff[1] + {{CNT_W{req.payload.coord_y[COORD_W-1]}}, req.payload.coord_y};
         sum_in[2] = sum_ff[2] + {{CNT_W{req.payload.coord_z[COORD_W-1]}}, req.payload.coord_z};
      end
      if (drop_vertex) begin
         dropped_in = 1'b1;
      end
      if (closing) begin
         empty_in = closing_empty;
         axis_in  = AXIS_X;
      end

      unique case (state_ff)
         S_DIV_WAIT: begin
            if (div_done) begin
               center_in[axis_ff] = div_quot;
               axis_in            = axis_ff + 1'b1;
               walk_idx_in        = '0;
               best_in            = '0;
            end
         end
         S_WALK_RD: begin
            phase_in = PHASE_FIRST;
         end
         S_WALK_MUL: begin
            phase_in = phase_ff + 1'b1;
            acc_in   = (phase_ff == PHASE_ACC_START) ? DIST_W'(prod_ff)
                                                     : acc_ff + DIST_W'(prod_ff);
         end
         S_WALK_CMP: begin
            best_in = best_next;
            if (walk_last) begin
               rem_in  = best_next;
               root_in = '0;
               bit_in  = DIST_W'(1) << (DIST_W - 2);
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         S_SQRT: begin
            // One digit of the floor square root per cycle.
            if (!sqrt_done) begin
               if (rem_ff >= root_plus_bit) begin
                  rem_in  = rem_ff - root_plus_bit;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_FIN: begin
            if (fin_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.center_x      = empty_ff ? '0 : center_ff[0];
               rsp_data_in.center_y      = empty_ff ? '0 : center_ff[1];
               rsp_data_in.center_z      = empty_ff ? '0 : center_ff[2];
               rsp_data_in.sphere_radius = empty_ff ? '0 : root_ff[RADIUS_W-1:0];
               rsp_data_in.empty_set     = empty_ff;
               rsp_data_in.overflowed    = dropped_ff;
               count_in                  = '0;
               sum_in                    = '0;
               dropped_in                = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      empty_ff    <= empty_in;
      axis_ff     <= axis_in;
      center_ff   <= center_in;
      walk_idx_ff <= walk_idx_in;
      phase_ff    <= phase_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Vertex store: one write port at the fill count, one registered read port for the walk.
   always_comb begin
      wr_word[0] = req.payload.coord_x;
      wr_word[1] = req.payload.coord_y;
      wr_word[2] = req.payload.coord_z;
   end

   always_ff @(posedge clock) begin
      if (add_vertex) begin
         store_mem[count_ff[ADDR_W-1:0]] <= wr_word;
      end
      rd_data_ff <= store_mem[walk_idx_ff[ADDR_W-1:0]];
   end

   // Shared divider forms the centroid one axis at a time.
   cbs_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W),
      .QUOT_W     (COORD_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(sum_ff[axis_ff])),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // The fill count never passes capacity, and the walk only reads written entries.
   `CBS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_VERTICES))
   `CBS_ASSERT_IMPLY(a_walk_in_range, clock, reset, state_ff == S_WALK_RD, walk_idx_ff < count_ff)
   // The divider only finishes while the sequencer waits for it.
   `CBS_ASSERT_IMPLY(a_div_done_wait, clock, reset, div_done, state_ff == S_DIV_WAIT)
   // A finished result is presented on the next cycle.
   `CBS_ASSERT_NEXT(a_result_shown, clock, reset, fin_load, rsp_valid_ff)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the centroid bounding sphere block.
// Depends on cbs_pkg, the cbs_req_if and cbs_rsp_if interfaces, and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cbs_pkg::*;

   localparam int CAPACITY      = 1024;
   localparam int RANDOM_ITEMS  = 1280;
   localparam int BIG_SET_AT    = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 40000;
   localparam int SETTLE_CYCLES = 200;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Predicts each sphere from the accepted vertex words and checks the result words.
   class sphere_scoreboard;
      logic signed [COORD_W-1:0] kept_x[CAPACITY];
      logic signed [COORD_W-1:0] kept_y[CAPACITY];
      logic signed [COORD_W-1:0] kept_z[CAPACITY];
      int unsigned kept_count = 0;
      longint acc_x = 0;
      longint acc_y = 0;
      longint acc_z = 0;
      bit dropped = 0;
      rsp_payload_type expected_spheres[$];
      int unsigned mismatches = 0;
      int unsigned spheres_predicted = 0;
      int unsigned spheres_checked = 0;
      int unsigned empty_sets = 0;
      int unsigned overflow_sets = 0;

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 26; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // Store and sum the vertex, and on a closing word work out the sphere.
      function void note_word(req_payload_type w);
         rsp_payload_type want;
         longint n;
         longint cx, cy, cz;
         longint dx, dy, dz;
         longint unsigned far, span;
         if (!w.no_vertex) begin
            if (kept_count < CAPACITY) begin
               kept_x[kept_count] = w.coord_x;
               kept_y[kept_count] = w.coord_y;
               kept_z[kept_count] = w.coord_z;
               acc_x += w.coord_x;
               acc_y += w.coord_y;
               acc_z += w.coord_z;
               kept_count++;
            end else begin
               dropped = 1'b1;
            end
         end
         if (!w.last) return;

         want = '0;
         far = 0;
         if (kept_count != 0) begin
            // Signed division truncates toward zero, as the centroid requires.
            n = kept_count;
            cx = acc_x / n;
            cy = acc_y / n;
            cz = acc_z / n;
            for (int i = 0; i < kept_count; i++) begin
               dx = kept_x[i] - cx;
               dy = kept_y[i] - cy;
               dz = kept_z[i] - cz;
               span = dx * dx + dy * dy + dz * dz;
               if (span > far) far = span;
            end
            want.center_x = cx[COORD_W-1:0];
            want.center_y = cy[COORD_W-1:0];
            want.center_z = cz[COORD_W-1:0];
            want.sphere_radius = RADIUS_W'(floor_root(far));
         end else begin
            empty_sets++;
         end
         want.empty_set = (kept_count == 0);
         want.overflowed = dropped;
         if (dropped) overflow_sets++;
         expected_spheres.push_back(want);
         spheres_predicted++;

         kept_count = 0;
         acc_x = 0;
         acc_y = 0;
         acc_z = 0;
         dropped = 1'b0;
      endfunction

      function void compare_field(string field, logic signed [63:0] want_v,
                                  logic signed [63:0] got_v);
         if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_sphere(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_spheres.size() == 0) begin
            $error("result word arrived with no sphere pending");
            mismatches++;
            return;
         end
         want = expected_spheres.pop_front();
         compare_field("center_x", want.center_x, got.center_x);
         compare_field("center_y", want.center_y, got.center_y);
         compare_field("center_z", want.center_z, got.center_z);
         compare_field("sphere_radius", want.sphere_radius, got.sphere_radius);
         compare_field("empty_set", want.empty_set, got.empty_set);
         compare_field("overflowed", want.overflowed, got.overflowed);
         spheres_checked++;
      endfunction

      function int unsigned outstanding();
         return expected_spheres.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles = 0;
   int   send_calm = 0;
   int   take_calm = 0;

   sphere_scoreboard sb = new;

   cbs_req_if req_ch();
   cbs_rsp_if rsp_ch();

   centroid_bounding_sphere #(
      .MAX_VERTICES(CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #5ns clock = ~clock;

   // Draws the wait before each word, with occasional stretches of back-to-back words.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   // Coordinate styles: full range, clustered around a base, or an extreme value.
   function automatic logic signed [COORD_W-1:0] pick_coord(int style,
                                                            logic signed [COORD_W-1:0] base);
      int pick;
      pick = (style == 3) ? $urandom_range(0, 2) : style;
      unique case (pick)
         0: return COORD_W'($urandom);
         1: return base + COORD_W'($urandom_range(0, 1023)) - COORD_W'(512);
         default: begin
            unique case ($urandom_range(0, 4))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               3: return '1;
               default: return COORD_W'(1);
            endcase
         end
      endcase
   endfunction

   // Offer one word and hold it until the block takes it.
   task automatic send_word(input logic signed [COORD_W-1:0] x, y, z,
                            input bit skip, input bit closes);
      req_payload_type word;
      int gap;
      word.coord_x = x;
      word.coord_y = y;
      word.coord_z = z;
      word.no_vertex = skip;
      word.last = closes;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= word;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_word(word);
   endtask

   // Stop offering until every predicted sphere has come back.
   task automatic wait_for_spheres();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Watchdog: end the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles.", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side: random stalls, plus two long hold-offs so the block backs up.
   initial begin : rsp_sink
      int gap;
      int taken;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      forever begin
         gap = (taken == 8 || taken == 16) ? HOLD_CYCLES : draw_gap(take_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         sb.check_sphere(rsp_ch.payload);
         taken++;
      end
   end

   // Vertex side: reset, directed sets, random sets, then drain and report.
   initial begin : req_source
      int counted;
      int size;
      int style;
      int pick;
      bit big_done;
      bit tail_close;
      logic signed [COORD_W-1:0] base;

      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty set, closed by a word that carries no vertex.
      send_word('0, '0, '0, 1'b1, 1'b1);
      // Single extreme vertex that also closes the set.
      send_word(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
      // Opposite corners with an ignored word between them; sum of -1 truncates to zero.
      send_word(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
      send_word(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
      send_word(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
      send_word(COORD_MIN, '0, COORD_MAX, 1'b1, 1'b1);
      // Negative sums must round toward zero.
      send_word(-24'sd3, 24'sd5, 24'sd0, 1'b0, 1'b0);
      send_word(-24'sd4, 24'sd6, 24'sd1, 1'b0, 1'b0);
      send_word(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1);
      send_word(-24'sd5, -24'sd5, -24'sd5, 1'b0, 1'b0);
      send_word(-24'sd2, -24'sd2, -24'sd2, 1'b0, 1'b1);
      // Mixed extremes on different axes.
      send_word(COORD_MAX, COORD_MIN, '0, 1'b0, 1'b0);
      send_word(COORD_MIN, COORD_MAX, '0, 1'b0, 1'b0);
      send_word('0, '0, COORD_MAX, 1'b0, 1'b1);
      // Two empty closes in a row.
      send_word(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      send_word(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
      wait_for_spheres();

      // Random sets: mostly small, one filled past capacity.
      counted = 0;
      big_done = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (!big_done && counted >= BIG_SET_AT) begin
            size = CAPACITY + 5;
            big_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) size = 0;
            else if (pick < 85) size = $urandom_range(1, 12);
            else size = $urandom_range(13, 64);
         end
         style = $urandom_range(0, 3);
         base = COORD_W'($urandom);
         tail_close = (size == 0) || ($urandom_range(0, 1) == 1);
         for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               send_word(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                         1'b1, 1'b0);
               counted++;
            end
            send_word(pick_coord(style, base), pick_coord(style, base),
                      pick_coord(style, base), 1'b0, !tail_close && (i == size - 1));
            counted++;
         end
         if (tail_close) begin
            send_word(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      1'b1, 1'b1);
            counted++;
         end
         if ($urandom_range(0, 9) == 0) wait_for_spheres();
      end

      wait_for_spheres();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d spheres (%0d empty, %0d past capacity) from %0d random words.",
               sb.spheres_checked, sb.empty_sets, sb.overflow_sets, counted);
      $display("Both channels stalled at random, with long result hold-offs and drains.");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
